@@ src/cdsf_pkg.sv @@
package cdsf_pkg;

    // coordinate storage
    localparam int AXES    = 6;
    localparam int AXIS_W  = 3;
    localparam int COORD_W = 32;

    // scalar formats: frequency Q8.8, time step Q0.16, products scaled by 2^-16
    localparam int FREQ_W     = 16;
    localparam int STEP_W     = 16;
    localparam int Q_FRAC     = 16;
    localparam int DAMP_SHIFT = 9;   // damping 2*f in Q16.16 is f shifted left by 9

    localparam logic [FREQ_W-1:0] FREQ_RESET = 16'd2048;

    // shared multiplier: signed operand times unsigned 32-bit scalar, 16 bits a pass
    localparam int MUL_A_W = 51;
    localparam int MUL_M_W = 32;
    localparam int CHUNK_W = 16;
    localparam int MUL_P_W = MUL_A_W + CHUNK_W + 1;
    localparam int MUL_S_W = MUL_P_W + CHUNK_W;
    localparam int MUL_R_W = MUL_S_W - Q_FRAC;

    // speed / position update before saturation
    localparam int SUM_W = MUL_A_W + 1;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = CFG_ADDR_W - 2;

    localparam logic [CFG_IDX_W-1:0] REG_FREQUENCY = '0;

    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_TARGET,
        KIND_SNAP,
        KIND_NONE
    } t_kind;

    typedef struct packed {
        t_kind                     kind;
        logic signed [COORD_W-1:0] eye_x;
        logic signed [COORD_W-1:0] eye_y;
        logic signed [COORD_W-1:0] eye_z;
        logic signed [COORD_W-1:0] look_x;
        logic signed [COORD_W-1:0] look_y;
        logic signed [COORD_W-1:0] look_z;
        logic [STEP_W-1:0]         time_step;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] cur_eye_x;
        logic signed [COORD_W-1:0] cur_eye_y;
        logic signed [COORD_W-1:0] cur_eye_z;
        logic signed [COORD_W-1:0] cur_look_x;
        logic signed [COORD_W-1:0] cur_look_y;
        logic signed [COORD_W-1:0] cur_look_z;
    } t_out_item;

    typedef enum logic [1:0] {
        MS_IDLE,
        MS_LO,
        MS_HI,
        MS_SUM
    } t_mul_st;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_FREQ,
        SQ_K,
        SQ_B,
        SQ_A,
        SQ_V,
        SQ_OUT
    } t_seq_st;

endpackage

@@ src/cdsf_mul.sv @@
module cdsf_mul (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [cdsf_pkg::MUL_A_W-1:0]   i_a,
    input  logic        [cdsf_pkg::MUL_M_W-1:0]   i_m,
    output logic                                  o_done,
    output logic signed [cdsf_pkg::MUL_R_W-1:0]   o_res
);
    import cdsf_pkg::*;

    // floor(a * m / 2^16), one 16-bit slice of m per cycle

    t_mul_st r_state;
    t_mul_st n_state;

    logic signed [MUL_A_W-1:0] r_a;
    logic        [MUL_M_W-1:0] r_m;
    logic signed [MUL_P_W-1:0] r_plo;
    logic signed [MUL_P_W-1:0] r_phi;
    logic signed [MUL_R_W-1:0] r_res;
    logic                      r_done;

    logic                      w_load_lo;
    logic                      w_load_hi;
    logic                      w_load_sum;
    logic        [CHUNK_W-1:0] w_chunk;
    logic signed [MUL_P_W-1:0] w_prod;
    logic signed [MUL_S_W-1:0] w_sum;

    always_comb begin
        n_state = r_state;
        case (r_state)
            MS_IDLE: begin
                if (i_start) begin
                    n_state = MS_LO;
                end
            end
            MS_LO:   n_state = MS_HI;
            MS_HI:   n_state = MS_SUM;
            MS_SUM:  n_state = MS_IDLE;
            default: n_state = MS_IDLE;
        endcase
    end

    always_comb begin
        w_load_lo  = 1'b0;
        w_load_hi  = 1'b0;
        w_load_sum = 1'b0;
        case (r_state)
            MS_LO:   w_load_lo  = 1'b1;
            MS_HI:   w_load_hi  = 1'b1;
            MS_SUM:  w_load_sum = 1'b1;
            default: ;
        endcase
    end

    assign w_chunk = w_load_hi ? r_m[MUL_M_W-1 -: CHUNK_W] : r_m[CHUNK_W-1:0];
    assign w_prod  = MUL_P_W'(r_a) * $signed({1'b0, w_chunk});
    assign w_sum   = MUL_S_W'(r_plo) + $signed({r_phi, {CHUNK_W{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= w_load_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == MS_IDLE && i_start) begin
            r_a <= i_a;
            r_m <= i_m;
        end
        if (w_load_lo) begin
            r_plo <= w_prod;
        end
        if (w_load_hi) begin
            r_phi <= w_prod;
        end
        if (w_load_sum) begin
            r_res <= w_sum[MUL_S_W-1:Q_FRAC];
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

@@ src/critically_damped_spring_follower.sv @@
// critically damped spring follower for a camera: eye xyz and look-at xyz
//
// input channel (i_in_valid / o_in_stall, payload i_in_item) takes one item
// at a time: a tick advances all six coordinates by one semi-implicit euler
// step of time_step seconds, a set-target item replaces the goals, a snap
// item forces current and goal and clears the speeds
// output channel (o_out_valid / i_out_stall, payload o_out_item) returns the
// six current coordinates once per item, held while i_out_stall is high
// frequency register (Q8.8) sits behind an apb-style port at address 0
//
// set-target, snap and the unused kind go from idle straight to the output
// state; a tick first runs its multiplier passes
// a tick runs 25 passes through the shared multiplier (one to square the
// frequency, then four per axis); that unit sets the rate
// the next item is taken once the result sits in the output register
// while the receiver stalls, the finished result is held and the block
// waits with its own result before dropping o_in_stall
// reset: frequency goes to 8.0, positions, goals and speeds to zero
module critically_damped_spring_follower (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,

    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  cdsf_pkg::t_in_item                     i_in_item,

    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output cdsf_pkg::t_out_item                    o_out_item,

    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [cdsf_pkg::CFG_ADDR_W-1:0]        paddr,
    input  logic [cdsf_pkg::CFG_DATA_W-1:0]        pwdata,
    output logic [cdsf_pkg::CFG_DATA_W-1:0]        prdata,
    output logic                                   pready
);
    import cdsf_pkg::*;

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [AXIS_W-1:0]         AXIS_LAST = AXIS_W'(AXES - 1);

    // sequencer
    t_seq_st r_state;
    t_seq_st n_state;

    // configuration
    logic [FREQ_W-1:0] r_freq;

    // spring state, one entry per axis
    logic signed [COORD_W-1:0] r_cur   [AXES];
    logic signed [COORD_W-1:0] r_goal  [AXES];
    logic signed [COORD_W-1:0] r_speed [AXES];

    // working registers of a tick
    logic [AXIS_W-1:0]         r_axis;
    logic                      r_pend;
    logic [STEP_W-1:0]         r_dt;
    logic [MUL_M_W-1:0]        r_k;
    logic signed [MUL_A_W-1:0] r_accel;

    // output register
    logic      r_out_valid;
    t_out_item r_out;

    logic                      w_cfg_wr;
    logic [CFG_IDX_W-1:0]      w_cfg_idx;
    logic                      w_in_accept;
    logic                      w_out_free;
    logic                      w_out_load;
    logic                      w_is_mul;
    logic                      w_mul_start;
    logic                      w_mul_done;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic        [MUL_M_W-1:0] w_mul_m;
    logic signed [MUL_R_W-1:0] w_mul_res;
    logic signed [MUL_A_W-1:0] w_res;
    logic signed [COORD_W:0]   w_delta;
    logic signed [COORD_W-1:0] w_base;
    logic signed [SUM_W-1:0]   w_sum;
    logic signed [COORD_W-1:0] w_sat;

    // ---------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------
    assign w_cfg_idx = paddr[CFG_ADDR_W-1:2];
    assign w_cfg_wr  = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (w_cfg_idx == REG_FREQUENCY) ?
                       {{(CFG_DATA_W-FREQ_W){1'b0}}, r_freq} : '0;

    // ---------------------------------------------------------------
    // handshakes
    // ---------------------------------------------------------------
    assign w_in_accept = i_in_valid && (r_state == SQ_IDLE);
    assign o_in_stall  = (r_state != SQ_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // ---------------------------------------------------------------
    // shared multiplier
    // ---------------------------------------------------------------
    cdsf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_m     (w_mul_m),
        .o_done  (w_mul_done),
        .o_res   (w_mul_res)
    );

    // products of interest all fit the operand width
    assign w_res   = w_mul_res[MUL_A_W-1:0];
    assign w_delta = (COORD_W+1)'(r_goal[r_axis]) - (COORD_W+1)'(r_cur[r_axis]);

    // ---------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            SQ_IDLE: begin
                if (w_in_accept) begin
                    if (i_in_item.kind == KIND_TICK) begin
                        n_state = SQ_FREQ;
                    end else begin
                        n_state = SQ_OUT;
                    end
                end
            end
            SQ_FREQ: if (w_mul_done) n_state = SQ_K;
            SQ_K:    if (w_mul_done) n_state = SQ_B;
            SQ_B:    if (w_mul_done) n_state = SQ_A;
            SQ_A:    if (w_mul_done) n_state = SQ_V;
            SQ_V: begin
                if (w_mul_done) begin
                    n_state = (r_axis == AXIS_LAST) ? SQ_OUT : SQ_K;
                end
            end
            SQ_OUT: if (w_out_free) n_state = SQ_IDLE;
            default: n_state = SQ_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // sequencer outputs: multiplier operands and the update path
    // ---------------------------------------------------------------
    always_comb begin
        w_is_mul = 1'b0;
        w_mul_a  = '0;
        w_mul_m  = '0;
        w_base   = r_cur[r_axis];
        case (r_state)
            SQ_FREQ: begin
                // stiffness f*f, taken as floor(f * (f << 16) / 2^16)
                w_is_mul = 1'b1;
                w_mul_a  = MUL_A_W'($signed({1'b0, r_freq}));
                w_mul_m  = {r_freq, {CHUNK_W{1'b0}}};
            end
            SQ_K: begin
                // spring term k * (goal - cur)
                w_is_mul = 1'b1;
                w_mul_a  = MUL_A_W'(w_delta);
                w_mul_m  = r_k;
            end
            SQ_B: begin
                // damping term 2f * speed
                w_is_mul = 1'b1;
                w_mul_a  = MUL_A_W'(r_speed[r_axis]);
                w_mul_m  = MUL_M_W'({r_freq, {DAMP_SHIFT{1'b0}}});
            end
            SQ_A: begin
                // speed increment accel * dt
                w_is_mul = 1'b1;
                w_mul_a  = r_accel;
                w_mul_m  = MUL_M_W'(r_dt);
                w_base   = r_speed[r_axis];
            end
            SQ_V: begin
                // position increment uses the new speed
                w_is_mul = 1'b1;
                w_mul_a  = MUL_A_W'(r_speed[r_axis]);
                w_mul_m  = MUL_M_W'(r_dt);
            end
            default: ;
        endcase
    end

    assign w_mul_start = w_is_mul && !r_pend;
    assign w_out_load  = (r_state == SQ_OUT) && w_out_free;

    // saturate the update to the coordinate range
    assign w_sum = SUM_W'(w_base) + SUM_W'(w_res);

    always_comb begin
        if (w_sum > SUM_W'(COORD_MAX)) begin
            w_sat = COORD_MAX;
        end else if (w_sum < SUM_W'(COORD_MIN)) begin
            w_sat = COORD_MIN;
        end else begin
            w_sat = w_sum[COORD_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // control and spring state
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SQ_IDLE;
            r_freq      <= FREQ_RESET;
            r_axis      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                r_cur[i]   <= '0;
                r_goal[i]  <= '0;
                r_speed[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (w_cfg_wr && w_cfg_idx == REG_FREQUENCY) begin
                r_freq <= pwdata[FREQ_W-1:0];
            end

            if (w_mul_start) begin
                r_pend <= 1'b1;
            end else if (w_mul_done) begin
                r_pend <= 1'b0;
            end

            if (w_in_accept) begin
                r_axis <= '0;
                case (i_in_item.kind)
                    KIND_TARGET: begin
                        r_goal[0] <= i_in_item.eye_x;
                        r_goal[1] <= i_in_item.eye_y;
                        r_goal[2] <= i_in_item.eye_z;
                        r_goal[3] <= i_in_item.look_x;
                        r_goal[4] <= i_in_item.look_y;
                        r_goal[5] <= i_in_item.look_z;
                    end
                    KIND_SNAP: begin
                        r_cur[0]  <= i_in_item.eye_x;
                        r_cur[1]  <= i_in_item.eye_y;
                        r_cur[2]  <= i_in_item.eye_z;
                        r_cur[3]  <= i_in_item.look_x;
                        r_cur[4]  <= i_in_item.look_y;
                        r_cur[5]  <= i_in_item.look_z;
                        r_goal[0] <= i_in_item.eye_x;
                        r_goal[1] <= i_in_item.eye_y;
                        r_goal[2] <= i_in_item.eye_z;
                        r_goal[3] <= i_in_item.look_x;
                        r_goal[4] <= i_in_item.look_y;
                        r_goal[5] <= i_in_item.look_z;
                        for (int i = 0; i < AXES; i++) begin
                            r_speed[i] <= '0;
                        end
                    end
                    default: ;
                endcase
            end

            if (w_mul_done) begin
                case (r_state)
                    SQ_A: r_speed[r_axis] <= w_sat;
                    SQ_V: begin
                        r_cur[r_axis] <= w_sat;
                        if (r_axis != AXIS_LAST) begin
                            r_axis <= r_axis + AXIS_W'(1);
                        end
                    end
                    default: ;
                endcase
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // working registers and output payload
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_dt <= i_in_item.time_step;
        end
        if (w_mul_done) begin
            case (r_state)
                SQ_FREQ: r_k     <= w_mul_res[MUL_M_W-1:0];
                SQ_K:    r_accel <= w_res;
                SQ_B:    r_accel <= r_accel - w_res;
                default: ;
            endcase
        end
        if (w_out_load) begin
            r_out.cur_eye_x  <= r_cur[0];
            r_out.cur_eye_y  <= r_cur[1];
            r_out.cur_eye_z  <= r_cur[2];
            r_out.cur_look_x <= r_cur[3];
            r_out.cur_look_y <= r_cur[4];
            r_out.cur_look_z <= r_cur[5];
        end
    end

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------

    // a multiplier result only comes back for a pass the sequencer issued
    a_done_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> r_pend)
        else $error("multiplier result without a pending pass");

    // a tick starts with the frequency square on the first axis
    a_tick_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && i_in_item.kind == KIND_TICK) |=>
        (r_state == SQ_FREQ && r_axis == '0))
        else $error("tick did not start at the first axis");

    // a finished result waits while the output register is still held
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SQ_OUT && r_out_valid && i_out_stall) |=>
        (r_state == SQ_OUT && o_in_stall))
        else $error("result left while the output was stalled");

    // the axis counter stays inside the six coordinates
    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SQ_V && w_mul_done && r_axis == AXIS_LAST) |=>
        (r_state == SQ_OUT && r_axis == AXIS_LAST))
        else $error("tick ran past the last axis");

endmodule
